FILE: rtl/dpb_pkg.sv
// Shared types, constants and register codes of the depth pixel back-projection block.
`default_nettype none
package dpb_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned StrideW  = 5;
  localparam int unsigned PointW   = 24;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned NumCells = ProdW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned MaxImageDim = 4096;

  localparam logic [CfgW-1:0]    FocalXRst  = 16'd9600;
  localparam logic [CfgW-1:0]    FocalYRst  = 16'd9600;
  localparam logic [CfgW-1:0]    CenterXRst = 16'd5120;
  localparam logic [CfgW-1:0]    CenterYRst = 16'd3840;
  localparam logic [CfgW-1:0]    MinDepRst  = 16'd100;
  localparam logic [CfgW-1:0]    MaxDepRst  = 16'd3000;
  localparam logic [StrideW-1:0] StrideRst  = 5'd2;

  typedef enum logic [CfgIdxW-1:0] {
    RegFocalX  = 3'd0,
    RegFocalY  = 3'd1,
    RegCenterX = 3'd2,
    RegCenterY = 3'd3,
    RegMinDep  = 3'd4,
    RegMaxDep  = 3'd5,
    RegStride  = 3'd6
  } cfg_reg_e;

  // Divisors seen by every cell of the division chain.
  typedef struct packed {
    logic [CfgW-1:0]    div_x;
    logic [CfgW-1:0]    div_y;
    logic [StrideW-1:0] stride;
  } div_cfg_t;

  // Data handed from cell to cell.
  typedef struct packed {
    logic               keep;
    logic               neg_x;
    logic               neg_y;
    logic [DepthW-1:0]  z;
    logic [ProdW-1:0]   dvd_x;
    logic [CfgW-1:0]    rem_x;
    logic [ProdW-1:0]   quo_x;
    logic [ProdW-1:0]   dvd_y;
    logic [CfgW-1:0]    rem_y;
    logic [ProdW-1:0]   quo_y;
    logic [CoordW-1:0]  mdv_u;
    logic [StrideW-1:0] rem_u;
    logic [CoordW-1:0]  mdv_v;
    logic [StrideW-1:0] rem_v;
  } cell_t;

endpackage
`default_nettype wire

FILE: rtl/dpb_front.sv
// Front stages: centering, depth range check, then the two Z products.
`default_nettype none
module dpb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dpb_pkg::CoordW-1:0]   column_i,
  input  logic [dpb_pkg::CoordW-1:0]   row_i,
  input  logic [dpb_pkg::DepthW-1:0]   depth_i,
  input  logic [dpb_pkg::CfgW-1:0]     center_x_i,
  input  logic [dpb_pkg::CfgW-1:0]     center_y_i,
  input  logic [dpb_pkg::CfgW-1:0]     min_depth_i,
  input  logic [dpb_pkg::CfgW-1:0]     max_depth_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dpb_pkg::cell_t               out_o
);

  logic                        a_valid_q;
  logic                        a_ready;
  logic                        a_keep_q, a_keep_d;
  logic                        a_negx_q, a_negx_d;
  logic                        a_negy_q, a_negy_d;
  logic [dpb_pkg::CfgW-1:0]    a_magx_q, a_magx_d;
  logic [dpb_pkg::CfgW-1:0]    a_magy_q, a_magy_d;
  logic [dpb_pkg::DepthW-1:0]  a_z_q;
  logic [dpb_pkg::CoordW-1:0]  a_u_q, a_v_q;
  logic [dpb_pkg::CfgW-1:0]    sc_u, sc_v;
  logic                        b_valid_q;
  logic                        b_ready;
  dpb_pkg::cell_t              b_q, b_d;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Coordinates move to the same 1/16 pixel scale as the principal point.
  assign sc_u = {column_i, 4'b0000};
  assign sc_v = {row_i, 4'b0000};

  always_comb begin
    a_negx_d = sc_u < center_x_i;
    a_negy_d = sc_v < center_y_i;
    a_magx_d = a_negx_d ? (center_x_i - sc_u) : (sc_u - center_x_i);
    a_magy_d = a_negy_d ? (center_y_i - sc_v) : (sc_v - center_y_i);
    a_keep_d = (depth_i != '0) && (depth_i >= min_depth_i) && (depth_i <= max_depth_i)
            && (32'(column_i) < dpb_pkg::MaxImageDim)
            && (32'(row_i) < dpb_pkg::MaxImageDim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_keep_q <= a_keep_d;
      a_negx_q <= a_negx_d;
      a_negy_q <= a_negy_d;
      a_magx_q <= a_magx_d;
      a_magy_q <= a_magy_d;
      a_z_q    <= depth_i;
      a_u_q    <= column_i;
      a_v_q    <= row_i;
    end
  end

  always_comb begin
    b_d       = '0;
    b_d.keep  = a_keep_q;
    b_d.neg_x = a_negx_q;
    b_d.neg_y = a_negy_q;
    b_d.z     = a_z_q;
    b_d.dvd_x = a_magx_q * a_z_q;
    b_d.dvd_y = a_magy_q * a_z_q;
    b_d.mdv_u = a_u_q;
    b_d.mdv_v = a_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule
`default_nettype wire

FILE: rtl/dpb_cell.sv
// One cell of the division chain: a quotient bit for X and Y, and a stride step if DoMod.
`default_nettype none
module dpb_cell #(
  parameter bit DoMod = 1'b1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpb_pkg::div_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dpb_pkg::cell_t    in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dpb_pkg::cell_t    out_o
);

  logic                          valid_q;
  dpb_pkg::cell_t                data_q, data_d;
  logic [dpb_pkg::CfgW:0]        trial_x, trial_y, diff_x, diff_y;
  logic                          qbit_x, qbit_y;
  logic [dpb_pkg::StrideW:0]     trial_u, trial_v, diff_u, diff_v;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d  = in_i;
    // Restoring division: bring down the next dividend bit and try the divisor.
    trial_x = {in_i.rem_x, in_i.dvd_x[dpb_pkg::ProdW-1]};
    trial_y = {in_i.rem_y, in_i.dvd_y[dpb_pkg::ProdW-1]};
    diff_x  = trial_x - {1'b0, cfg_i.div_x};
    diff_y  = trial_y - {1'b0, cfg_i.div_y};
    qbit_x  = trial_x >= {1'b0, cfg_i.div_x};
    qbit_y  = trial_y >= {1'b0, cfg_i.div_y};
    data_d.rem_x = qbit_x ? diff_x[dpb_pkg::CfgW-1:0] : trial_x[dpb_pkg::CfgW-1:0];
    data_d.rem_y = qbit_y ? diff_y[dpb_pkg::CfgW-1:0] : trial_y[dpb_pkg::CfgW-1:0];
    data_d.dvd_x = {in_i.dvd_x[dpb_pkg::ProdW-2:0], 1'b0};
    data_d.dvd_y = {in_i.dvd_y[dpb_pkg::ProdW-2:0], 1'b0};
    data_d.quo_x = {in_i.quo_x[dpb_pkg::ProdW-2:0], qbit_x};
    data_d.quo_y = {in_i.quo_y[dpb_pkg::ProdW-2:0], qbit_y};

    trial_u = {in_i.rem_u, in_i.mdv_u[dpb_pkg::CoordW-1]};
    trial_v = {in_i.rem_v, in_i.mdv_v[dpb_pkg::CoordW-1]};
    diff_u  = trial_u - {1'b0, cfg_i.stride};
    diff_v  = trial_v - {1'b0, cfg_i.stride};
    if (DoMod) begin
      data_d.rem_u = (trial_u >= {1'b0, cfg_i.stride}) ? diff_u[dpb_pkg::StrideW-1:0]
                                                       : trial_u[dpb_pkg::StrideW-1:0];
      data_d.rem_v = (trial_v >= {1'b0, cfg_i.stride}) ? diff_v[dpb_pkg::StrideW-1:0]
                                                       : trial_v[dpb_pkg::StrideW-1:0];
      data_d.mdv_u = {in_i.mdv_u[dpb_pkg::CoordW-2:0], 1'b0};
      data_d.mdv_v = {in_i.mdv_v[dpb_pkg::CoordW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
`default_nettype wire

FILE: rtl/dpb_back.sv
// Output stage: stride verdict, sign, saturation and the result register.
`default_nettype none
module dpb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dpb_pkg::cell_t              in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        keep_o,
  output logic [dpb_pkg::PointW-1:0]  point_x_o,
  output logic [dpb_pkg::PointW-1:0]  point_y_o,
  output logic [dpb_pkg::DepthW-1:0]  point_z_o
);

  localparam logic [dpb_pkg::ProdW-1:0]  PosLim = 32'h007F_FFFF;
  localparam logic [dpb_pkg::PointW-1:0] NegSat = 24'h80_0000;

  logic                         valid_q;
  logic                         keep_q, keep_d;
  logic [dpb_pkg::PointW-1:0]   x_q, x_d, y_q, y_d;
  logic [dpb_pkg::DepthW-1:0]   z_q, z_d;

  assign in_ready_o = !valid_q || out_ready_i;

  function automatic logic [dpb_pkg::PointW-1:0] sat_point(
    input logic                       neg,
    input logic [dpb_pkg::ProdW-1:0]  quo
  );
    logic [dpb_pkg::PointW-1:0] res;
    if (quo > PosLim) begin
      res = neg ? NegSat : PosLim[dpb_pkg::PointW-1:0];
    end else begin
      res = neg ? (~quo[dpb_pkg::PointW-1:0] + 1'b1) : quo[dpb_pkg::PointW-1:0];
    end
    return res;
  endfunction

  always_comb begin
    keep_d = in_i.keep && (in_i.rem_u == '0) && (in_i.rem_v == '0);
    x_d    = '0;
    y_d    = '0;
    z_d    = '0;
    if (keep_d) begin
      x_d = sat_point(in_i.neg_x, in_i.quo_x);
      y_d = sat_point(in_i.neg_y, in_i.quo_y);
      z_d = in_i.z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      keep_q <= keep_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign out_valid_o = valid_q;
  assign keep_o      = keep_q;
  assign point_x_o   = x_q;
  assign point_y_o   = y_q;
  assign point_z_o   = z_q;

endmodule
`default_nettype wire

FILE: rtl/depth_pixel_backprojection.sv
// Top level of the pinhole depth pixel back-projection block.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: column, row, depth_mm
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: x, y, z; tuser: keep
//   cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// One item enters per cycle when nothing stalls; each item passes, in order, through
// two front stages (centering, then the Z products), a chain of 32 division cells
// that each settle one quotient bit, and the output register.
// Reset clears every stage valid and loads the register defaults; no clearing pass.
// Each stage holds while the one after it is full and stalled, so empty stages
// still take items while a result waits on m_axis.
`default_nettype none
module depth_pixel_backprojection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // column [11:0], row [23:12], depth_mm [39:24]
  input  logic [dpb_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // point_x_mm [23:0], point_y_mm [47:24], point_z_mm [63:48]
  output logic [dpb_pkg::OutDataW-1:0]  m_axis_tdata,
  // keep [0]
  output logic                          m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [dpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dpb_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned NumCells = dpb_pkg::NumCells;

  logic [dpb_pkg::CfgW-1:0]    focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [dpb_pkg::CfgW-1:0]    min_dep_q, max_dep_q;
  logic [dpb_pkg::StrideW-1:0] stride_q;
  dpb_pkg::div_cfg_t           div_cfg;

  dpb_pkg::cell_t              link   [NumCells+1];
  logic                        link_v [NumCells+1];
  logic                        link_r [NumCells+1];

  logic [dpb_pkg::PointW-1:0]  point_x, point_y;
  logic [dpb_pkg::DepthW-1:0]  point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= dpb_pkg::FocalXRst;
      focal_y_q  <= dpb_pkg::FocalYRst;
      center_x_q <= dpb_pkg::CenterXRst;
      center_y_q <= dpb_pkg::CenterYRst;
      min_dep_q  <= dpb_pkg::MinDepRst;
      max_dep_q  <= dpb_pkg::MaxDepRst;
      stride_q   <= dpb_pkg::StrideRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpb_pkg::RegFocalX:  focal_x_q  <= cfg_data_i;
        dpb_pkg::RegFocalY:  focal_y_q  <= cfg_data_i;
        dpb_pkg::RegCenterX: center_x_q <= cfg_data_i;
        dpb_pkg::RegCenterY: center_y_q <= cfg_data_i;
        dpb_pkg::RegMinDep:  min_dep_q  <= cfg_data_i;
        dpb_pkg::RegMaxDep:  max_dep_q  <= cfg_data_i;
        dpb_pkg::RegStride:  stride_q   <= cfg_data_i[dpb_pkg::StrideW-1:0];
        default: ;
      endcase
    end
  end

  // A zero focal length or stride acts as one.
  always_comb begin
    div_cfg.div_x  = (focal_x_q == '0) ? dpb_pkg::CfgW'(1) : focal_x_q;
    div_cfg.div_y  = (focal_y_q == '0) ? dpb_pkg::CfgW'(1) : focal_y_q;
    div_cfg.stride = (stride_q == '0) ? dpb_pkg::StrideW'(1) : stride_q;
  end

  dpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .column_i    (s_axis_tdata[11:0]),
    .row_i       (s_axis_tdata[23:12]),
    .depth_i     (s_axis_tdata[39:24]),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .min_depth_i (min_dep_q),
    .max_depth_i (max_dep_q),
    .out_valid_o (link_v[0]),
    .out_ready_i (link_r[0]),
    .out_o       (link[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    dpb_cell #(
      .DoMod (k < dpb_pkg::CoordW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (div_cfg),
      .in_valid_i  (link_v[k]),
      .in_ready_o  (link_r[k]),
      .in_i        (link[k]),
      .out_valid_o (link_v[k+1]),
      .out_ready_i (link_r[k+1]),
      .out_o       (link[k+1])
    );
  end

  dpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (link_v[NumCells]),
    .in_ready_o  (link_r[NumCells]),
    .in_i        (link[NumCells]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .keep_o      (m_axis_tuser),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .point_z_o   (point_z)
  );

  assign m_axis_tdata = {point_z, point_y, point_x};

endmodule
`default_nettype wire

FILE: rtl/dpb_checker.sv
// Port-level checks on the back-projection block, bound to its top level.
`default_nettype none
module dpb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dpb_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser
);

  // A dropped pixel carries an all-zero point.
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("dropped item with nonzero point");

  // A kept pixel always has a depth reading.
  a_keep_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:48] != '0)
    else $error("kept item with zero depth");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Reset has emptied the pipeline by the following edge.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result shown during reset");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);
`default_nettype wire
